### hw/rtl/fml_pkg.sv
// ----------------------------------------------------------------------------
// fml_pkg
// Shared types and constants for the fragment match locator: register
// indexes, field widths and the fragment configuration bundle.
// ----------------------------------------------------------------------------
package fml_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_SEQ_LEN_DEF  = 256;
  localparam int MAX_FRAG_LEN_DEF = 16;

  // Fixed field widths
  localparam int CHAR_W     = 8;
  localparam int LEN_W      = 5;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int FRAG_CHARS = 16;
  localparam int HALF_CHARS = 8;
  localparam int HIT_W      = 9;
  localparam int START_W    = 8;

  localparam logic [HIT_W-1:0] HIT_MAX = '1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAG_LEN   = 2'd0,
    REG_CHARS_LOW  = 2'd1,
    REG_CHARS_HIGH = 2'd2
  } cfg_reg_t;

  // Fragment as seen by the datapath; length already clamped
  typedef struct packed {
    logic [LEN_W-1:0]                  length;
    logic [FRAG_CHARS-1:0][CHAR_W-1:0] chars;
  } frag_cfg_t;

endpackage

### hw/rtl/fml_cfg_regs.sv
// ----------------------------------------------------------------------------
// fml_cfg_regs
// Fragment configuration registers with the write port, and the clamping of
// the fragment length to the supported range.
// ----------------------------------------------------------------------------
module fml_cfg_regs
  import fml_pkg::*;
#(
  parameter int MAX_FRAG_LEN = MAX_FRAG_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output frag_cfg_t             frag_cfg
);

  logic [LEN_W-1:0]      frag_len_raw;
  logic [CFG_DATA_W-1:0] chars_low;
  logic [CFG_DATA_W-1:0] chars_high;

  // Register writes; an index with no register behind it is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      frag_len_raw <= LEN_W'(1);
      chars_low    <= '0;
      chars_high   <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_FRAG_LEN:   frag_len_raw <= cfg_data[LEN_W-1:0];
        REG_CHARS_LOW:  chars_low    <= cfg_data;
        REG_CHARS_HIGH: chars_high   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Zero acts as one, anything past the window depth as the depth
  always_comb begin
    frag_cfg.chars = {chars_high, chars_low};
    priority if (frag_len_raw == '0)
      frag_cfg.length = LEN_W'(1);
    else if (frag_len_raw > LEN_W'(MAX_FRAG_LEN))
      frag_cfg.length = LEN_W'(MAX_FRAG_LEN);
    else
      frag_cfg.length = frag_len_raw;
  end

endmodule

### hw/rtl/fml_match.sv
// ----------------------------------------------------------------------------
// fml_match
// Window compare: checks every candidate fragment length against the
// shifted window in parallel, then picks the configured length.
// ----------------------------------------------------------------------------
module fml_match
  import fml_pkg::*;
#(
  parameter int MAX_FRAG_LEN = MAX_FRAG_LEN_DEF
) (
  input  logic [MAX_FRAG_LEN-1:0][CHAR_W-1:0] window,
  input  frag_cfg_t                           frag_cfg,
  output logic                                hit
);

  logic [MAX_FRAG_LEN-1:0] hit_by_len;

  // Entry 0 is the newest character, so fragment char k sits at L-1-k
  always_comb begin
    for (int l = 1; l <= MAX_FRAG_LEN; l++) begin
      hit_by_len[l-1] = 1'b1;
      for (int k = 0; k < l; k++) begin
        if (window[l-1-k] != frag_cfg.chars[k])
          hit_by_len[l-1] = 1'b0;
      end
    end
  end

  // Select the result for the active length
  always_comb begin
    hit = 1'b0;
    for (int l = 1; l <= MAX_FRAG_LEN; l++) begin
      if (frag_cfg.length == LEN_W'(l))
        hit = hit_by_len[l-1];
    end
  end

endmodule

### hw/rtl/fragment_match_locator_unit.sv
// ----------------------------------------------------------------------------
// fragment_match_locator_unit
// Streams sequence characters past a configured fragment and reports every
// start position at which the fragment occurs, with per-sequence totals.
// ----------------------------------------------------------------------------
// One character is taken per item and one result is given per item. The
// block accepts a new item in every clock cycle unless the output stalls;
// each item passes an input register and a result register, which holds
// its result during an output stall. The rate is set by the window compare,
// which checks all fragment lengths in parallel in the cycle an item leaves
// the input register. The user writes configuration between items while the
// block is idle; the block does not enforce it. Characters past MAX_SEQ_LEN
// in one sequence are ignored and raise too_long until that sequence ends.
// ----------------------------------------------------------------------------
module fragment_match_locator_unit
  import fml_pkg::*;
#(
  parameter int MAX_SEQ_LEN  = MAX_SEQ_LEN_DEF,
  parameter int MAX_FRAG_LEN = MAX_FRAG_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CHAR_W-1:0]     symbol,
  input  logic                  last_symbol,
  // output channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  match_found,
  output logic [START_W-1:0]    match_start,
  output logic                  sequence_end,
  output logic [HIT_W-1:0]      hit_total,
  output logic                  too_long
);

  localparam int IDX_W = $clog2(MAX_SEQ_LEN + 1);
  localparam int SUB_W = (IDX_W > START_W) ? IDX_W : START_W;

  frag_cfg_t frag_cfg;

  // Input register
  logic              s1_valid;
  logic [CHAR_W-1:0] s1_symbol;
  logic              s1_last;

  // Sequence state
  logic [MAX_FRAG_LEN-1:0][CHAR_W-1:0] window;
  logic [MAX_FRAG_LEN-1:0][CHAR_W-1:0] window_next;
  logic [IDX_W-1:0]                    symbol_index;
  logic [IDX_W-1:0]                    symbol_index_next;
  logic [HIT_W-1:0]                    hit_counter;
  logic [HIT_W-1:0]                    hit_counter_next;
  logic                                overflow_seen;
  logic                                overflow_next;

  logic             out_free;
  logic             proc;
  logic             in_accept;
  logic             seq_full;
  logic             window_hit;
  logic             found;
  logic [SUB_W-1:0] start_full;

  fml_cfg_regs #(
    .MAX_FRAG_LEN (MAX_FRAG_LEN)
  ) u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .frag_cfg     (frag_cfg)
  );

  // Handshake: output register frees when empty or being taken
  assign out_free  = !out_valid || !out_stall;
  assign proc      = s1_valid && out_free;
  assign in_stall  = s1_valid && !out_free;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (proc) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_symbol <= symbol;
      s1_last   <= last_symbol;
    end
  end

  // Window shifted by the new character
  always_comb begin
    window_next[0] = s1_symbol;
    for (int i = 1; i < MAX_FRAG_LEN; i++)
      window_next[i] = window[i-1];
  end

  fml_match #(
    .MAX_FRAG_LEN (MAX_FRAG_LEN)
  ) u_match (
    .window   (window_next),
    .frag_cfg (frag_cfg),
    .hit      (window_hit)
  );

  assign seq_full          = (symbol_index == IDX_W'(MAX_SEQ_LEN));
  assign symbol_index_next = symbol_index + IDX_W'(1);
  assign found = !seq_full && window_hit &&
                 (symbol_index_next >= IDX_W'(frag_cfg.length));
  assign start_full = SUB_W'(symbol_index_next) - SUB_W'(frag_cfg.length);

  // Counters after this character, before any end-of-sequence clear
  always_comb begin
    hit_counter_next = hit_counter;
    if (found && hit_counter != HIT_MAX)
      hit_counter_next = hit_counter + HIT_W'(1);
    overflow_next = overflow_seen || seq_full;
  end

  // Sequence state update
  always_ff @(posedge clk) begin
    if (rst) begin
      window        <= '0;
      symbol_index  <= '0;
      hit_counter   <= '0;
      overflow_seen <= 1'b0;
    end else if (proc) begin
      if (s1_last) begin
        window        <= '0;
        symbol_index  <= '0;
        hit_counter   <= '0;
        overflow_seen <= 1'b0;
      end else if (seq_full) begin
        overflow_seen <= 1'b1;
      end else begin
        window       <= window_next;
        symbol_index <= symbol_index_next;
        hit_counter  <= hit_counter_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      match_found  <= found;
      match_start  <= found ? start_full[START_W-1:0] : '0;
      sequence_end <= s1_last;
      hit_total    <= hit_counter_next;
      too_long     <= overflow_next;
    end
  end

`ifndef ASSERT_OFF
  // A reported hit is always counted
  a_hit_counted : assert property (@(posedge clk) disable iff (rst)
    out_valid && match_found |-> hit_total != '0)
    else $error("match reported with zero hit total");

  // Once a sequence overflows no further match may be reported
  a_no_match_after_overflow : assert property (@(posedge clk) disable iff (rst)
    out_valid && too_long |-> !match_found)
    else $error("match reported in an overflowed sequence");

  // The end of a sequence clears its counters
  a_seq_clear : assert property (@(posedge clk) disable iff (rst)
    proc && s1_last |=> symbol_index == '0 && hit_counter == '0 && !overflow_seen)
    else $error("sequence state not cleared at end of sequence");

  // Character index never passes the sequence limit
  a_index_bound : assert property (@(posedge clk) disable iff (rst)
    symbol_index <= IDX_W'(MAX_SEQ_LEN))
    else $error("symbol index beyond maximum sequence length");

  // Input side is held back only while the input register is occupied
  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("input stalled without a waiting item");
`endif

endmodule

### tb/sv/tb_fragment_match_locator_unit.sv
// ----------------------------------------------------------------------------
// tb_fragment_match_locator_unit
// Self-checking bench for the fragment match locator. A short table of
// directed items comes first; hand-typed results cover reset defaults,
// length clamping and a full-length fragment. Random sequences follow under
// a series of fragment settings, with random gaps on the input side and
// random stalls on the result side. The remaining results are checked against
// an in-bench model of the window compare.
// ----------------------------------------------------------------------------
module tb_fragment_match_locator_unit
  import fml_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEQ_LIMIT   = MAX_SEQ_LEN_DEF;
  localparam int ITEM_TARGET = 1900;

  // One result item as the block presents it
  typedef struct packed {
    logic               found;
    logic [START_W-1:0] start;
    logic               seq_end;
    logic [HIT_W-1:0]   hits;
    logic               too_long;
  } match_report_t;

  // One row of the directed table: a fragment setting or an item
  typedef struct {
    bit                  is_cfg;
    logic [LEN_W-1:0]    len;
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
    logic [CHAR_W-1:0]   sym;
    bit                  last;
    bit                  typed;
    match_report_t       want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write_en = 1'b0;
  cfg_reg_t              cfg_index = REG_FRAG_LEN;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CHAR_W-1:0]     symbol = '0;
  logic                  last_symbol = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  match_found;
  logic [START_W-1:0]    match_start;
  logic                  sequence_end;
  logic [HIT_W-1:0]      hit_total;
  logic                  too_long;

  // Model state: fragment setting and per-sequence scan state
  logic [8*FRAG_CHARS-1:0]      frag_text = '0;
  int                           frag_span = 1;
  logic [CHAR_W-1:0]            recent_chars [FRAG_CHARS] = '{default: '0};
  int                           seq_pos = 0;
  logic [HIT_W-1:0]             hit_count = '0;
  bit                           overflow_seen = 1'b0;

  match_report_t pending_reports[$];
  plan_row_t     directed_plan[$];
  int            fail_count = 0;
  bit            send_calm = 1'b0;

  fragment_match_locator_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .symbol       (symbol),
    .last_symbol  (last_symbol),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .match_found  (match_found),
    .match_start  (match_start),
    .sequence_end (sequence_end),
    .hit_total    (hit_total),
    .too_long     (too_long)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Wait before an item or a result; now and then switch to a calm stretch
  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 23) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  // Advance the scan by one character and give the result it causes
  function automatic match_report_t scan_symbol(input logic [CHAR_W-1:0] sym,
                                                input bit last);
    match_report_t r;
    bit same;
    r = '0;
    if (seq_pos >= SEQ_LIMIT) begin
      // past the length limit: ignored, only flagged
      overflow_seen = 1'b1;
    end else begin
      for (int i = FRAG_CHARS - 1; i > 0; i--) recent_chars[i] = recent_chars[i-1];
      recent_chars[0] = sym;
      seq_pos++;
      if (seq_pos >= frag_span) begin
        same = 1'b1;
        for (int k = 0; k < frag_span; k++) begin
          if (recent_chars[frag_span-1-k] != frag_text[8*k +: 8]) same = 1'b0;
        end
        if (same) begin
          r.found = 1'b1;
          r.start = START_W'(seq_pos - frag_span);
          if (hit_count != HIT_MAX) hit_count++;
        end
      end
    end
    r.seq_end  = last;
    r.hits     = hit_count;
    r.too_long = overflow_seen;
    if (last) begin
      foreach (recent_chars[i]) recent_chars[i] = '0;
      seq_pos       = 0;
      hit_count     = '0;
      overflow_seen = 1'b0;
    end
    return r;
  endfunction

  // Offer one item, hold it until taken, then record its expected result
  task automatic push_item(input logic [CHAR_W-1:0] sym, input bit last,
                           input bit typed, input match_report_t want);
    int gap;
    match_report_t model_out;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    symbol      <= sym;
    last_symbol <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model_out = scan_symbol(sym, last);
    pending_reports.push_back(typed ? want : model_out);
  endtask

  // Let every outstanding result come back, then allow the pipeline to settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all three fragment registers back to back
  task automatic apply_config(input logic [LEN_W-1:0] len,
                              input logic [CFG_DATA_W-1:0] lo,
                              input logic [CFG_DATA_W-1:0] hi);
    logic [CFG_DATA_W-1:0] len_word;
    len_word = {$urandom(), $urandom()};
    len_word[LEN_W-1:0] = len;
    cfg_write_en <= 1'b1;
    cfg_index    <= REG_FRAG_LEN;
    cfg_data     <= len_word;
    @(posedge clk);
    cfg_index <= REG_CHARS_LOW;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= REG_CHARS_HIGH;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    frag_text = {hi, lo};
    // zero acts as one, anything past the window acts as a full window
    frag_span = (len == 0) ? 1 : ((len > FRAG_CHARS) ? FRAG_CHARS : int'(len));
  endtask

  task automatic plan_cfg(input logic [LEN_W-1:0] len,
                          input logic [CFG_DATA_W-1:0] lo,
                          input logic [CFG_DATA_W-1:0] hi);
    plan_row_t row;
    row        = '{default: '0};
    row.is_cfg = 1'b1;
    row.len    = len;
    row.lo     = lo;
    row.hi     = hi;
    directed_plan.push_back(row);
  endtask

  task automatic plan_item(input logic [CHAR_W-1:0] sym, input bit last,
                           input bit typed, input bit found,
                           input int start, input int hits);
    plan_row_t row;
    row       = '{default: '0};
    row.sym   = sym;
    row.last  = last;
    row.typed = typed;
    row.want  = {found, START_W'(start), last, HIT_W'(hits), 1'b0};
    directed_plan.push_back(row);
  endtask

  // Result side: random stalls, compare each result with the oldest expectation
  initial begin : report_check
    match_report_t got;
    match_report_t want;
    bit calm;
    int hold;
    calm = 1'b0;
    @(negedge rst);
    forever begin
      hold = draw_wait(calm);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got = {match_found, match_start, sequence_end, hit_total, too_long};
      if (pending_reports.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected result: found=%0d start=%0d end=%0d hits=%0d too_long=%0d",
                   got.found, got.start, got.seq_end, got.hits, got.too_long);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        if (got !== want) begin
          if (fail_count < 10)
            $display({"mismatch: expected found=%0d start=%0d end=%0d hits=%0d too_long=%0d",
                      " | got found=%0d start=%0d end=%0d hits=%0d too_long=%0d"},
                     want.found, want.start, want.seq_end, want.hits, want.too_long,
                     got.found, got.start, got.seq_end, got.hits, got.too_long);
          fail_count++;
        end
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    logic [CHAR_W-1:0]      seq_chars[$];
    logic [CHAR_W-1:0]      alpha[4];
    logic [CHAR_W-1:0]      fill;
    logic [LEN_W-1:0]       new_len;
    logic [8*FRAG_CHARS-1:0] new_text;
    bit                     noisy;
    int                     sent;
    int                     budget;
    int                     seq_len;
    int                     pos;
    int                     pick;

    // Reset defaults: one-character fragment of zero
    plan_item(8'h00, 1'b0, 1'b1, 1'b1, 0, 1);
    plan_item(8'hFF, 1'b0, 1'b1, 1'b0, 0, 1);
    plan_item(8'h00, 1'b1, 1'b1, 1'b1, 2, 2);
    // Length zero acts as one; single-character sequence
    plan_cfg(5'd0, '1, '0);
    plan_item(8'hFF, 1'b1, 1'b1, 1'b1, 0, 1);
    // Full sixteen-character fragment, sequence exactly as long
    plan_cfg(5'd16, 64'h0706050403020100, 64'hFFFEFDFCFBFAF9F8);
    for (int k = 0; k < FRAG_CHARS; k++)
      plan_item((k < 8) ? CHAR_W'(k) : CHAR_W'(8'hF0 + k), k == FRAG_CHARS - 1, 1'b1,
                k == FRAG_CHARS - 1, 0, (k == FRAG_CHARS - 1) ? 1 : 0);
    // Length above the window clamps; sequence shorter than the fragment
    plan_cfg(5'd31, 64'h0706050403020100, 64'hFFFEFDFCFBFAF9F8);
    plan_item(8'h00, 1'b0, 1'b1, 1'b0, 0, 0);
    plan_item(8'h01, 1'b1, 1'b1, 1'b0, 0, 0);
    // Overlapping occurrences of a two-character fragment
    plan_cfg(5'd2, 64'h6161, '0);
    for (int k = 0; k < 4; k++) plan_item(8'h61, k == 3, 1'b0, 1'b0, 0, 0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_cfg) begin
        drain();
        apply_config(directed_plan[i].len, directed_plan[i].lo, directed_plan[i].hi);
      end else begin
        push_item(directed_plan[i].sym, directed_plan[i].last,
                  directed_plan[i].typed, directed_plan[i].want);
      end
    end

    // Random phases, each under a fresh fragment setting
    sent = 0;
    while (sent < ITEM_TARGET) begin
      drain();
      case ($urandom_range(0, 9))
        0:       new_len = 5'd0;
        1:       new_len = 5'd1;
        2:       new_len = 5'd16;
        3:       new_len = LEN_W'($urandom_range(17, 31));
        default: new_len = LEN_W'($urandom_range(2, 15));
      endcase
      foreach (alpha[i]) alpha[i] = CHAR_W'($urandom());
      case ($urandom_range(0, 3))
        0: for (int k = 0; k < FRAG_CHARS; k++) new_text[8*k +: 8] = alpha[$urandom_range(0, 1)];
        1: begin
          // one repeated character gives heavily overlapping hits
          case ($urandom_range(0, 2))
            0:       fill = 8'h00;
            1:       fill = 8'hFF;
            default: fill = alpha[0];
          endcase
          for (int k = 0; k < FRAG_CHARS; k++) new_text[8*k +: 8] = fill;
        end
        2: new_text = {$urandom(), $urandom(), $urandom(), $urandom()};
        default: for (int k = 0; k < FRAG_CHARS; k++) new_text[8*k +: 8] = alpha[$urandom_range(0, 3)];
      endcase
      apply_config(new_len, new_text[63:0], new_text[127:64]);

      budget = sent + $urandom_range(100, 250);
      while (sent < budget && sent < ITEM_TARGET) begin
        case ($urandom_range(0, 39))
          0:       seq_len = $urandom_range(SEQ_LIMIT + 1, SEQ_LIMIT + 44);
          1:       seq_len = SEQ_LIMIT;
          2:       seq_len = frag_span;
          3:       seq_len = (frag_span > 1) ? $urandom_range(1, frag_span - 1) : 1;
          default: seq_len = $urandom_range(1, 40);
        endcase
        noisy = ($urandom_range(0, 4) == 0);
        seq_chars.delete();
        while (seq_chars.size() < seq_len) begin
          if (noisy) begin
            seq_chars.push_back(CHAR_W'($urandom()));
          end else if ($urandom_range(0, 3) == 0) begin
            // spliced copy of the fragment, sometimes with one character broken
            pos = ($urandom_range(0, 3) == 0) ? $urandom_range(0, frag_span - 1) : -1;
            for (int k = 0; k < frag_span; k++)
              seq_chars.push_back(frag_text[8*k +: 8] ^
                                  ((k == pos) ? CHAR_W'($urandom_range(1, 255)) : 8'h00));
          end else if ($urandom_range(0, 7) == 0) begin
            seq_chars.push_back(CHAR_W'($urandom()));
          end else begin
            pick = $urandom_range(0, frag_span - 1);
            seq_chars.push_back(frag_text[8*pick +: 8]);
          end
        end
        for (int i = 0; i < seq_len; i++)
          push_item(seq_chars[i], i == seq_len - 1, 1'b0, '0);
        sent += seq_len;
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### fragment_match_locator_unit.f
hw/rtl/fml_pkg.sv
hw/rtl/fml_cfg_regs.sv
hw/rtl/fml_match.sv
hw/rtl/fragment_match_locator_unit.sv
tb/sv/tb_fragment_match_locator_unit.sv
